@@ rtl/core/lscc_pkg.sv @@
// shared constants, types and register codes for the linear stretch color composite
// no dependencies
package lscc_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int BAND_W      = 8;
    localparam int LEVEL_W     = 8;
    localparam int CODE_W      = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 8;
    localparam int NUM_REGS    = 7;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int NUM_W       = 17;
    localparam int PROD_W      = 25;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RED_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RED_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_LOW  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREEN_HIGH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLUE_HIGH  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MODE  = 3'd6;

    // register reset values
    localparam logic [BAND_W-1:0] RESET_LOW       = 8'd0;
    localparam logic [BAND_W-1:0] RESET_HIGH      = 8'd255;
    localparam logic              RESET_FULL_MODE = 1'b1;

    // level counts and top levels
    localparam logic [LEVEL_W-1:0] FULL_TOP    = 8'd255;
    localparam logic [LEVEL_W-1:0] PAL_TOP     = 8'd5;
    localparam logic [NUM_W-1:0]   FULL_LEVELS = 17'd256;
    localparam logic [NUM_W-1:0]   PAL_LEVELS  = 17'd6;

    // boundary quotient: full mode divides by 512, palette mode by 12
    localparam int           FULL_SHIFT = 9;
    localparam int           PAL_SHIFT  = 16;
    localparam int           PAL_NUM_W  = 12;
    localparam logic [12:0]  PAL_RECIP  = 13'd5462;

    typedef struct packed {
        logic [BAND_W-1:0] first_band;
        logic [BAND_W-1:0] second_band;
        logic [BAND_W-1:0] third_band;
    } t_pixel;

    typedef struct packed {
        logic [BAND_W-1:0] lo;
        logic [BAND_W-1:0] hi;
    } t_stretch;

    typedef struct packed {
        t_stretch red;
        t_stretch green;
        t_stretch blue;
        logic     full_mode;
    } t_cfg;

    typedef struct packed {
        logic               en;
        logic [ADDR_W-1:0]  addr;
        logic [LEVEL_W-1:0] data;
    } t_tbl_wr;

endpackage

@@ rtl/core/lscc_if.sv @@
// handshake channel interfaces: pixel in, color code out, register writes
// depends on lscc_pkg
interface lscc_pixel_if;
    import lscc_pkg::*;
    logic              valid;
    logic              ready;
    logic [BAND_W-1:0] first_band;
    logic [BAND_W-1:0] second_band;
    logic [BAND_W-1:0] third_band;
    modport source (output valid, output first_band, output second_band, output third_band,
                    input ready);
    modport sink   (input valid, input first_band, input second_band, input third_band,
                    output ready);
endinterface

interface lscc_code_if;
    import lscc_pkg::*;
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] color_code;
    modport source (output valid, output color_code, input ready);
    modport sink   (input valid, input color_code, output ready);
endinterface

interface lscc_cfg_if;
    import lscc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/lscc_ram.sv @@
// generic memory: one write port, one read port with registered read data
// no dependencies
module lscc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/core/lscc_front.sv @@
// front end: accepts pixel items into a short queue ahead of the lookup stage
// depends on lscc_pkg and lscc_if
module lscc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    lscc_pixel_if.sink         i_pixel,
    input  logic               i_pop,
    output logic               o_nonempty,
    output lscc_pkg::t_pixel   o_head
);
    import lscc_pkg::*;

    t_pixel            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic [QPTR_W:0]   n_count;
    logic              push;
    logic              pop;

    assign i_pixel.ready = (r_count != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign push          = i_pixel.valid && i_pixel.ready;
    assign pop           = i_pop && o_nonempty;
    assign o_nonempty    = (r_count != '0);
    assign o_head        = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= '{first_band:  i_pixel.first_band,
                                 second_band: i_pixel.second_band,
                                 third_band:  i_pixel.third_band};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end
endmodule

@@ rtl/core/lscc_build.sv @@
// table builder for one band: sweeps all entries, one level step or one write a cycle
// depends on lscc_pkg
module lscc_build (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  lscc_pkg::t_stretch i_band,
    input  logic               i_full_mode,
    output lscc_pkg::t_tbl_wr  o_wr,
    output logic               o_busy
);
    import lscc_pkg::*;

    logic                r_busy;
    logic [ADDR_W-1:0]   r_j;
    logic [LEVEL_W-1:0]  r_k;
    logic [NUM_W-1:0]    r_num;

    logic [LEVEL_W-1:0]  top;
    logic [BAND_W-1:0]   span;
    logic [NUM_W-1:0]    span2;
    logic                ordered;
    logic                in_range;
    logic [PROD_W-1:0]   prod;
    logic [LEVEL_W-1:0]  quot;
    logic [BAND_W:0]     end_pos;
    logic                step_k;

    assign top      = i_full_mode ? FULL_TOP : PAL_TOP;
    assign span     = i_band.hi - i_band.lo;
    assign span2    = {(NUM_W - BAND_W - 1)'(0), span, 1'b0};
    assign ordered  = (i_band.lo <= i_band.hi);
    assign in_range = ordered && (r_j >= i_band.lo) && (r_j <= i_band.hi);

    // rounded boundary lo + (2*span*(k+1) + L) / (2L), numerator kept in r_num
    assign prod    = {(PROD_W - PAL_NUM_W)'(0), r_num[PAL_NUM_W-1:0]}
                   * {(PROD_W - 13)'(0), PAL_RECIP};
    assign quot    = i_full_mode ? r_num[FULL_SHIFT +: LEVEL_W] : prod[PAL_SHIFT +: LEVEL_W];
    assign end_pos = {1'b0, i_band.lo} + {1'b0, quot};
    assign step_k  = in_range && ({1'b0, r_j} > end_pos);

    assign o_busy    = r_busy;
    assign o_wr.en   = r_busy && !step_k;
    assign o_wr.addr = r_j;
    assign o_wr.data = in_range ? r_k : ((r_j <= i_band.hi) ? '0 : top);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_j    <= '0;
            r_k    <= '0;
            r_num  <= span2 + (i_full_mode ? FULL_LEVELS : PAL_LEVELS);
        end else if (r_busy) begin
            if (step_k) begin
                r_k   <= r_k + 1'b1;
                r_num <= r_num + span2;
            end else if (r_j == ADDR_W'(TABLE_DEPTH - 1)) begin
                r_busy <= 1'b0;
            end else begin
                r_j <= r_j + 1'b1;
            end
        end
    end
endmodule

@@ rtl/core/lscc_back.sv @@
// back end: table build sequencing, level lookup and color code output register
// depends on lscc_pkg, lscc_if, lscc_ram and lscc_build
module lscc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lscc_pkg::t_cfg   i_cfg,
    input  logic             i_cfg_write,
    input  logic             i_nonempty,
    input  lscc_pkg::t_pixel i_head,
    output logic             o_pop,
    lscc_code_if.source      o_code
);
    import lscc_pkg::*;

    localparam logic [1:0] ST_STALE = 2'd0;
    localparam logic [1:0] ST_BUILD = 2'd1;
    localparam logic [1:0] ST_READY = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic               r_s1_valid;
    logic               r_out_valid;
    logic [CODE_W-1:0]  r_out_code;

    logic               start;
    logic               any_busy;
    logic               can_out;
    t_tbl_wr            wr_r;
    t_tbl_wr            wr_g;
    t_tbl_wr            wr_b;
    logic               busy_r;
    logic               busy_g;
    logic               busy_b;
    logic [LEVEL_W-1:0] lvl_r;
    logic [LEVEL_W-1:0] lvl_g;
    logic [LEVEL_W-1:0] lvl_b;
    logic [15:0]        pal_code;
    logic [CODE_W-1:0]  code;

    assign start    = (r_state == ST_STALE) && i_nonempty;
    assign any_busy = busy_r || busy_g || busy_b;
    assign can_out  = !r_out_valid || o_code.ready;
    assign o_pop    = i_nonempty && (r_state == ST_READY) && (!r_s1_valid || can_out);

    lscc_build u_build_r (.i_clk, .i_rst_n, .i_start(start), .i_band(i_cfg.red),
                          .i_full_mode(i_cfg.full_mode), .o_wr(wr_r), .o_busy(busy_r));
    lscc_build u_build_g (.i_clk, .i_rst_n, .i_start(start), .i_band(i_cfg.green),
                          .i_full_mode(i_cfg.full_mode), .o_wr(wr_g), .o_busy(busy_g));
    lscc_build u_build_b (.i_clk, .i_rst_n, .i_start(start), .i_band(i_cfg.blue),
                          .i_full_mode(i_cfg.full_mode), .o_wr(wr_b), .o_busy(busy_b));

    lscc_ram #(.WIDTH(LEVEL_W), .DEPTH(TABLE_DEPTH)) u_ram_r (
        .i_clk, .i_we(wr_r.en), .i_waddr(wr_r.addr), .i_wdata(wr_r.data),
        .i_re(o_pop), .i_raddr(i_head.first_band), .o_rdata(lvl_r));
    lscc_ram #(.WIDTH(LEVEL_W), .DEPTH(TABLE_DEPTH)) u_ram_g (
        .i_clk, .i_we(wr_g.en), .i_waddr(wr_g.addr), .i_wdata(wr_g.data),
        .i_re(o_pop), .i_raddr(i_head.second_band), .o_rdata(lvl_g));
    lscc_ram #(.WIDTH(LEVEL_W), .DEPTH(TABLE_DEPTH)) u_ram_b (
        .i_clk, .i_we(wr_b.en), .i_waddr(wr_b.addr), .i_wdata(wr_b.data),
        .i_re(o_pop), .i_raddr(i_head.third_band), .o_rdata(lvl_b));

    // palette index 36r + 6g + b as shifts and adds
    assign pal_code = {3'b0, lvl_r, 5'b0} + {6'b0, lvl_r, 2'b0}
                    + {6'b0, lvl_g, 2'b0} + {7'b0, lvl_g, 1'b0}
                    + {8'b0, lvl_b};
    assign code     = i_cfg.full_mode ? {lvl_b, lvl_g, lvl_r}
                                      : {(CODE_W - 16)'(0), pal_code};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_STALE: begin
                if (i_nonempty) begin
                    n_state = ST_BUILD;
                end
            end
            ST_BUILD: begin
                if (!any_busy) begin
                    n_state = ST_READY;
                end
            end
            ST_READY: n_state = ST_READY;
            default:  n_state = ST_STALE;
        endcase
        if (i_cfg_write) begin
            n_state = ST_STALE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_STALE;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_s1_valid <= 1'b1;
            end else if (can_out) begin
                r_s1_valid <= 1'b0;
            end
            if (can_out) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_out && r_s1_valid) begin
            r_out_code <= code;
        end
    end

    assign o_code.valid      = r_out_valid;
    assign o_code.color_code = r_out_code;
endmodule

@@ rtl/core/linear_stretch_color_composite.sv @@
// top level of the linear stretch color composite: register file, front queue, back end
// depends on lscc_pkg, lscc_if, lscc_front and lscc_back

// Each pixel item carries three 8-bit bands (first = red, second = green, third = blue).
// Every band is mapped through its own 256-entry level table, a linear stretch between
// that band's low and high registers, and the three levels are packed as r | g<<8 | b<<16
// in full-color mode (256 levels) or combined as 36r + 6g + b in palette mode (6 levels).
// The tables live in three 256 x 8 memories. After reset and after every register write
// the tables are stale; the first pixel that arrives then waits while three builders
// sweep the tables in parallel, one entry write or one level step per cycle, a sweep being
// 256 entry writes plus up to 255 level steps in full-color mode, far fewer in palette
// mode. Once built, the block takes one pixel per cycle while the output is not stalled:
// a four-entry queue feeds the memory read port, and each accepted item passes through
// the queue, the registered memory read and the output register before its code is valid.
// The output register decouples a stalled consumer from the input side until the queue
// fills.
// Register writes are always accepted; write them only while no item is in flight.
module linear_stretch_color_composite (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lscc_pixel_if.sink   i_pixel,
    lscc_code_if.source  o_code,
    lscc_cfg_if.sink     i_cfg
);
    import lscc_pkg::*;

    t_cfg   r_cfg;
    logic   cfg_write;
    logic   nonempty;
    logic   pop;
    t_pixel head;

    // register port never stalls
    assign i_cfg.ready = 1'b1;

    // an out-of-range index is dropped and leaves the tables as they are
    assign cfg_write = i_cfg.valid && (i_cfg.index < CFG_IDX_W'(NUM_REGS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.red       <= '{lo: RESET_LOW, hi: RESET_HIGH};
            r_cfg.green     <= '{lo: RESET_LOW, hi: RESET_HIGH};
            r_cfg.blue      <= '{lo: RESET_LOW, hi: RESET_HIGH};
            r_cfg.full_mode <= RESET_FULL_MODE;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_RED_LOW:    r_cfg.red.lo    <= i_cfg.data;
                REG_RED_HIGH:   r_cfg.red.hi    <= i_cfg.data;
                REG_GREEN_LOW:  r_cfg.green.lo  <= i_cfg.data;
                REG_GREEN_HIGH: r_cfg.green.hi  <= i_cfg.data;
                REG_BLUE_LOW:   r_cfg.blue.lo   <= i_cfg.data;
                REG_BLUE_HIGH:  r_cfg.blue.hi   <= i_cfg.data;
                REG_FULL_MODE:  r_cfg.full_mode <= i_cfg.data[0];
                default: begin
                    // unmapped index, nothing to write
                end
            endcase
        end
    end

    // front: accept and hold pixel items
    lscc_front u_front (
        .i_clk,
        .i_rst_n,
        .i_pixel,
        .i_pop      (pop),
        .o_nonempty (nonempty),
        .o_head     (head)
    );

    // back: rebuild tables when stale, then look up and emit
    lscc_back u_back (
        .i_clk,
        .i_rst_n,
        .i_cfg       (r_cfg),
        .i_cfg_write (cfg_write),
        .i_nonempty  (nonempty),
        .i_head      (head),
        .o_pop       (pop),
        .o_code
    );
endmodule

@@ rtl/core/lscc_checker.sv @@
// port-level checks for the linear stretch color composite, bound to the top level
// depends on lscc_pkg
module lscc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_pix_valid,
    input logic                            i_pix_ready,
    input logic                            i_code_valid,
    input logic                            i_code_ready,
    input logic [lscc_pkg::CODE_W-1:0]     i_code,
    input logic                            i_cfg_valid,
    input logic                            i_cfg_ready,
    input logic [lscc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [lscc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lscc_pkg::*;

    localparam logic [3:0]        MAX_INFLIGHT = 4'd6;
    localparam logic [CODE_W-1:0] PAL_LIMIT    = 24'd216;

    logic       r_mode;
    logic [3:0] r_outstanding;
    logic       in_fire;
    logic       out_fire;

    assign in_fire  = i_pix_valid && i_pix_ready;
    assign out_fire = i_code_valid && i_code_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= RESET_FULL_MODE;
            r_outstanding <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_ready && i_cfg_index == REG_FULL_MODE) begin
                r_mode <= i_cfg_data[0];
            end
            if (in_fire && !out_fire) begin
                r_outstanding <= r_outstanding + 1'b1;
            end else if (out_fire && !in_fire) begin
                r_outstanding <= r_outstanding - 1'b1;
            end
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_code_valid && !i_code_ready |=> i_code_valid && $stable(i_code))
        else $error("color code changed or dropped while stalled");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_fire |-> r_outstanding != 4'd0)
        else $error("result delivered with no pixel outstanding");

    a_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outstanding <= MAX_INFLIGHT)
        else $error("more pixels in flight than the block can hold");

    a_palette_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_code_valid && !r_mode |-> i_code < PAL_LIMIT)
        else $error("palette index out of range");
endmodule

bind linear_stretch_color_composite lscc_checker u_lscc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_pix_valid  (i_pixel.valid),
    .i_pix_ready  (i_pixel.ready),
    .i_code_valid (o_code.valid),
    .i_code_ready (o_code.ready),
    .i_code       (o_code.color_code),
    .i_cfg_valid  (i_cfg.valid),
    .i_cfg_ready  (i_cfg.ready),
    .i_cfg_index  (i_cfg.index),
    .i_cfg_data   (i_cfg.data)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// testbench for linear_stretch_color_composite: pixel items checked against an in-bench
// model of the three stretch tables, under random idling and receiver backpressure
// depends on lscc_pkg, the lscc channel interfaces and the block's rtl

module testbench;
    import lscc_pkg::*;

    // index with no register behind it, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
    // long enough to outlast a full table build, so results back up behind the hold
    localparam int HOLD_CYCLES     = 700;
    localparam int ITEMS_PER_PHASE = 103;
    localparam int RANDOM_PHASES   = 9;

    // one line of the directed stimulus table
    typedef struct packed {
        logic                  is_write;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] wr_data;
        t_pixel                px;
        logic                  known;
        logic [CODE_W-1:0]     code;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lscc_pixel_if pix_ch();
    lscc_code_if  code_ch();
    lscc_cfg_if   cfg_ch();

    linear_stretch_color_composite dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pixel (pix_ch),
        .o_code  (code_ch),
        .i_cfg   (cfg_ch)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // bench copy of the registers and the level tables
    logic [BAND_W-1:0]  stretch_lo [3];
    logic [BAND_W-1:0]  stretch_hi [3];
    logic               full_mode;
    logic               levels_built;
    logic [LEVEL_W-1:0] band_levels [3][TABLE_DEPTH];

    // color codes still owed by the block, oldest first
    logic [CODE_W-1:0] expected_codes [$];
    int mismatches = 0;

    // idling knobs, in percent of cycles
    int unsigned send_idle_pct = 13;
    int unsigned recv_idle_pct = 47;

    // long receiver holds: the stimulus raises a request, the ready process serves it
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    t_row directed [$];

    // fill one band's table: a linear stretch between its low and high raw values
    function automatic void stretch_band(int band);
        int lo, hi, levels, span, start, stop;
        logic [LEVEL_W-1:0] top_level;
        lo        = int'(stretch_lo[band]);
        hi        = int'(stretch_hi[band]);
        top_level = full_mode ? FULL_TOP : PAL_TOP;
        // hard threshold at high, which is all that is left when low is above high
        for (int j = 0; j < TABLE_DEPTH; j++)
            band_levels[band][j] = (j <= hi) ? '0 : top_level;
        if (lo <= hi) begin
            span   = hi - lo;
            levels = int'(top_level) + 1;
            start  = lo;
            // level k ends at lo + round(span * (k + 1) / levels), halves rounded up
            for (int k = 0; k <= int'(top_level); k++) begin
                stop = lo + (2 * span * (k + 1) + levels) / (2 * levels);
                for (int j = start; j <= stop && j < TABLE_DEPTH; j++)
                    band_levels[band][j] = LEVEL_W'(k);
                start = stop + 1;
            end
        end
    endfunction

    // color code for one pixel; tables are rebuilt lazily after any register change
    function automatic logic [CODE_W-1:0] composite_code(t_pixel px);
        logic [LEVEL_W-1:0] r, g, b;
        if (!levels_built) begin
            for (int band = 0; band < 3; band++)
                stretch_band(band);
            levels_built = 1'b1;
        end
        r = band_levels[0][px.first_band];
        g = band_levels[1][px.second_band];
        b = band_levels[2][px.third_band];
        if (full_mode)
            return {b, g, r};
        return CODE_W'(36 * int'(r) + 6 * int'(g) + int'(b));
    endfunction

    // register write as the block sees it: masked to width, unknown index dropped
    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_RED_LOW:    stretch_lo[0] = data;
            REG_RED_HIGH:   stretch_hi[0] = data;
            REG_GREEN_LOW:  stretch_lo[1] = data;
            REG_GREEN_HIGH: stretch_hi[1] = data;
            REG_BLUE_LOW:   stretch_lo[2] = data;
            REG_BLUE_HIGH:  stretch_hi[2] = data;
            REG_FULL_MODE:  full_mode     = data[0];
            default:        return;
        endcase
        levels_built = 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input logic [CODE_W-1:0] got,
                                   input logic [CODE_W-1:0] want);
        $display("[%0t] %s: got 0x%06h, expected 0x%06h", $time, what, got, want);
        mismatches++;
    endtask

    // random band value, often right at or next to the stretch edges
    function automatic logic [BAND_W-1:0] pick_band(int band);
        int v;
        case ($urandom_range(9))
            0, 1:    v = int'(stretch_lo[band]) + int'($urandom_range(4)) - 2;
            2, 3:    v = int'(stretch_hi[band]) + int'($urandom_range(4)) - 2;
            4:       v = $urandom_range(1) ? 255 : 0;
            default: v = int'($urandom_range(255));
        endcase
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return BAND_W'(v);
    endfunction

    task automatic add_pixel(input int r, input int g, input int b, input logic known,
                             input logic [CODE_W-1:0] code);
        t_row row;
        row                = '0;
        row.px.first_band  = BAND_W'(r);
        row.px.second_band = BAND_W'(g);
        row.px.third_band  = BAND_W'(b);
        row.known          = known;
        row.code           = code;
        directed.push_back(row);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        t_row row;
        row          = '0;
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.wr_data  = data;
        directed.push_back(row);
    endtask

    // offer one pixel item, starting and ending at a falling edge; valid is left high between
    // back-to-back items, the caller lowers it when it stops sending
    task automatic send_pixel(input t_pixel px, input logic known,
                              input logic [CODE_W-1:0] typed_code);
        logic [CODE_W-1:0] want;
        while ($urandom_range(99) < send_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.first_band  <= px.first_band;
        pix_ch.second_band <= px.second_band;
        pix_ch.third_band  <= px.third_band;
        do @(posedge i_clk); while (!pix_ch.ready);
        // predictor always runs so its tables track the block, typed rows win
        want = composite_code(px);
        expected_codes.push_back(known ? typed_code : want);
        @(negedge i_clk);
    endtask

    // one register write; valid stays high for a following write like pixel items
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        apply_register(idx, data);
        @(negedge i_clk);
    endtask

    // stop sending, wait for every owed code, let the pipeline go quiet, then set the
    // idling knobs for what follows (at a rising edge, clear of the ready process)
    task automatic settle(input int unsigned send_pct, input int unsigned recv_pct,
                          input logic long_hold);
        pix_ch.valid <= 1'b0;
        while (expected_codes.size() != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        if (long_hold)
            hold_requests++;
        @(negedge i_clk);
    endtask

    // new stretch for every band, both register orders of magnitude, then the mode
    task automatic random_setting(input int phase);
        int lo, hi;
        for (int band = 0; band < 3; band++) begin
            case ($urandom_range(5))
                0: begin lo = 0; hi = 255; end
                1: begin
                    lo = int'($urandom_range(255));
                    hi = int'($urandom_range(255, lo));
                end
                // low may well land above high here
                2: begin
                    lo = int'($urandom_range(255));
                    hi = int'($urandom_range(255));
                end
                3: begin lo = int'($urandom_range(255)); hi = lo; end
                4: begin lo = 255; hi = 0; end
                default: begin
                    lo = int'($urandom_range(250));
                    hi = lo + int'($urandom_range(5));
                end
            endcase
            write_register(band == 0 ? REG_RED_LOW :
                           band == 1 ? REG_GREEN_LOW : REG_BLUE_LOW, BAND_W'(lo));
            write_register(band == 0 ? REG_RED_HIGH :
                           band == 1 ? REG_GREEN_HIGH : REG_BLUE_HIGH, BAND_W'(hi));
        end
        // a stray write to the unused index must leave the tables alone
        if ($urandom_range(2) == 0)
            write_register(REG_NONE, CFG_DATA_W'($urandom_range(255)));
        // mode alternates per phase, upper data bits random and ignored
        write_register(REG_FULL_MODE, {7'($urandom_range(127)), phase[0]});
    endtask

    // receiver: random idling plus the occasional long hold
    initial begin
        code_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                code_ch.ready <= 1'b0;
            end else if (hold_served != hold_requests) begin
                hold_served++;
                hold_left = HOLD_CYCLES;
                code_ch.ready <= 1'b0;
            end else begin
                code_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // result check: every code against the oldest one owed
    always @(posedge i_clk) begin
        if (i_rst_n && code_ch.valid && code_ch.ready) begin
            if (expected_codes.size() == 0) begin
                report_mismatch("color code with no pixel pending", code_ch.color_code, '0);
            end else begin
                if (code_ch.color_code !== expected_codes[0])
                    report_mismatch("color_code mismatch", code_ch.color_code,
                                    expected_codes[0]);
                void'(expected_codes.pop_front());
            end
        end
    end

    // main sequence
    initial begin
        t_pixel px;
        logic   last_write;

        pix_ch.valid       = 1'b0;
        pix_ch.first_band  = '0;
        pix_ch.second_band = '0;
        pix_ch.third_band  = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        i_rst_n            = 1'b0;

        // bench registers start at their reset values, tables unbuilt
        for (int band = 0; band < 3; band++) begin
            stretch_lo[band] = RESET_LOW;
            stretch_hi[band] = RESET_HIGH;
        end
        full_mode    = RESET_FULL_MODE;
        levels_built = 1'b0;

        // directed table: reset defaults first, full color
        add_pixel(0, 0, 0, 1'b1, 24'h000000);
        add_pixel(255, 255, 255, 1'b1, 24'hFFFFFF);
        add_pixel(1, 2, 128, 1'b0, '0);
        add_pixel(254, 127, 3, 1'b0, '0);
        // palette mode through a write with junk in the upper bits
        add_write(REG_FULL_MODE, 8'hFE);
        add_pixel(255, 255, 255, 1'b1, 24'd215);
        add_pixel(0, 0, 0, 1'b1, 24'd0);
        add_pixel(127, 128, 200, 1'b0, '0);
        // write to a missing register, tables stay as built
        add_write(REG_NONE, 8'h55);
        add_pixel(42, 85, 170, 1'b0, '0);
        // red low above high, green low equal to high, blue pinned at the top
        add_write(REG_RED_LOW, 8'd200);
        add_write(REG_RED_HIGH, 8'd100);
        add_write(REG_GREEN_LOW, 8'd77);
        add_write(REG_GREEN_HIGH, 8'd77);
        add_write(REG_BLUE_LOW, 8'd255);
        add_write(REG_BLUE_HIGH, 8'd255);
        add_write(REG_FULL_MODE, 8'h01);
        add_pixel(100, 77, 255, 1'b1, 24'h000000);
        add_pixel(101, 78, 254, 1'b1, 24'h00FFFF);
        add_pixel(0, 76, 0, 1'b0, '0);
        // same thresholds in palette mode
        add_write(REG_FULL_MODE, 8'h00);
        add_pixel(101, 78, 254, 1'b1, 24'd210);
        add_pixel(100, 77, 255, 1'b1, 24'd0);

        // synchronous reset, released at a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // walk the table; writes only go out once the block has drained
        last_write = 1'b0;
        foreach (directed[i]) begin
            if (directed[i].is_write) begin
                if (!last_write)
                    settle(send_idle_pct, recv_idle_pct, 1'b0);
                write_register(directed[i].reg_idx, directed[i].wr_data);
            end else begin
                if (last_write)
                    cfg_ch.valid <= 1'b0;
                send_pixel(directed[i].px, directed[i].known, directed[i].code);
            end
            last_write = directed[i].is_write;
        end

        // random phases: sender light / receiver heavy idling, then swapped, then none;
        // one phase opens with a long receiver hold so the input side backs up
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase < 3)
                settle(13, 47, 1'b0);
            else if (phase < 6)
                settle(47, 13, 1'b0);
            else
                settle(0, 0, phase == 7);
            random_setting(phase);
            cfg_ch.valid <= 1'b0;
            repeat (ITEMS_PER_PHASE) begin
                px.first_band  = pick_band(0);
                px.second_band = pick_band(1);
                px.third_band  = pick_band(2);
                send_pixel(px, 1'b0, '0);
            end
        end

        settle(0, 0, 1'b0);
        if (mismatches == 0 && expected_codes.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/lscc_pkg.sv
rtl/core/lscc_if.sv
rtl/core/lscc_ram.sv
rtl/core/lscc_front.sv
rtl/core/lscc_build.sv
rtl/core/lscc_back.sv
rtl/core/linear_stretch_color_composite.sv
rtl/core/lscc_checker.sv
tb/testbench.sv
